FILE: hw/rtl/dcrm_pkg.sv
// Shared types and constants of the depth class run merger.
`default_nettype none

package dcrm_pkg;

    // Field widths
    localparam int CONTIG_ID_BITS = 16;
    localparam int DEPTH_BITS     = 16;
    localparam int POS_W          = 32;
    localparam int HAP_W          = 12;
    localparam int SUM_W          = 40;
    localparam int TALLY_W        = 24;
    localparam int MEAN_W         = 24;
    localparam int TOTAL_W        = 48;
    localparam int CLASS_W        = 3;

    // APB port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Threshold compare width: k*hap + ceil(hap/2) for k up to 4
    localparam int THR_W = HAP_W + 3;
    localparam int CMP_W = (DEPTH_BITS > THR_W) ? DEPTH_BITS : THR_W;

    // Shared iterative unit
    localparam int WORK_W  = TOTAL_W;             // dividend / multiplier shift register
    localparam int REM_W   = TALLY_W;             // remainder, divisor fits in the tally width
    localparam int LEN_W   = POS_W + 1;           // segment length
    localparam int MCAND_W = LEN_W;
    localparam int ACC_W   = TOTAL_W;
    localparam int ALU_W   = ACC_W + 2;
    localparam int CNT_W   = $clog2(WORK_W + 1);

    // Step counts of the shared unit
    localparam int QUOT_W          = SUM_W;              // floor(depth_sum / tally)
    localparam int RATIO_DIVIDEND_W = QUOT_W + 2;        // 2q + hap
    localparam int MULT_W          = RATIO_DIVIDEND_W - 1;
    localparam int DIV_MEAN_STEPS  = WORK_W;
    localparam int DIV_RATIO_STEPS = RATIO_DIVIDEND_W;
    localparam int MUL_REP_STEPS   = MULT_W;
    localparam int MUL_CLS_STEPS   = CLASS_W;

    // Register indexes
    typedef enum logic [0:0] {
        REG_COMBINED_HAP = 1'b0,
        REG_HIFI_HAP     = 1'b1
    } reg_idx_t;

    // Depth classes
    typedef enum logic [CLASS_W-1:0] {
        CLS_HAP    = 3'd0,
        CLS_DIP    = 3'd1,
        CLS_TRIP   = 3'd2,
        CLS_TETRAP = 3'd3,
        CLS_REPEAT = 3'd4
    } class_t;

    // Shared unit operations
    typedef enum logic [0:0] {
        IU_DIV = 1'b0,
        IU_MUL = 1'b1
    } iu_op_t;

    typedef struct packed {
        logic             start;
        iu_op_t           op;
        logic [CNT_W-1:0] count;
    } iu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } iu_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dcrm_win_if.sv
// Input channel: depth windows and flush words.
`default_nettype none

interface dcrm_win_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [dcrm_pkg::CONTIG_ID_BITS-1:0] contig_id;
    logic [dcrm_pkg::POS_W-1:0]          win_start;
    logic [dcrm_pkg::POS_W-1:0]          win_end;
    logic [dcrm_pkg::DEPTH_BITS-1:0]     combined_depth;
    logic [dcrm_pkg::DEPTH_BITS-1:0]     hifi_depth;
    logic [dcrm_pkg::POS_W-1:0]          contig_length;

    modport source (
        output valid, kind, contig_id, win_start, win_end,
               combined_depth, hifi_depth, contig_length,
        input  ready
    );

    modport sink (
        input  valid, kind, contig_id, win_start, win_end,
               combined_depth, hifi_depth, contig_length,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/dcrm_seg_if.sv
// Output channel: merged segments.
`default_nettype none

interface dcrm_seg_if;
    logic                                valid;
    logic                                ready;
    logic [dcrm_pkg::CONTIG_ID_BITS-1:0] seg_contig;
    logic [dcrm_pkg::POS_W-1:0]          seg_first;
    logic [dcrm_pkg::POS_W-1:0]          seg_last;
    logic [dcrm_pkg::MEAN_W-1:0]         mean_depth_x256;
    logic [dcrm_pkg::TALLY_W-1:0]        windows_merged;
    logic [dcrm_pkg::POS_W-1:0]          seg_contig_length;
    logic [dcrm_pkg::CLASS_W-1:0]        seg_class;
    logic [dcrm_pkg::TOTAL_W-1:0]        represented_total;

    modport source (
        output valid, seg_contig, seg_first, seg_last, mean_depth_x256,
               windows_merged, seg_contig_length, seg_class, represented_total,
        input  ready
    );

    modport sink (
        input  valid, seg_contig, seg_first, seg_last, mean_depth_x256,
               windows_merged, seg_contig_length, seg_class, represented_total,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/dcrm_iter_unit.sv
// Shared shift-and-subtract / shift-and-add unit: one bit per cycle.
`default_nettype none

module dcrm_iter_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dcrm_pkg::iu_cmd_t              cmd,
    input  wire logic [dcrm_pkg::WORK_W-1:0]    opa,
    input  wire logic [dcrm_pkg::MCAND_W-1:0]   opb,
    output dcrm_pkg::iu_stat_t                  stat,
    output logic [dcrm_pkg::WORK_W-1:0]         quot,
    output logic [dcrm_pkg::ACC_W-1:0]          prod
);

    dcrm_pkg::iu_op_t                 op_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [dcrm_pkg::CNT_W-1:0]       cnt_reg;
    logic [dcrm_pkg::WORK_W-1:0]      work_reg;
    logic [dcrm_pkg::MCAND_W-1:0]     opb_reg;
    logic [dcrm_pkg::REM_W-1:0]       rem_reg;
    logic [dcrm_pkg::ACC_W-1:0]       acc_reg;
    logic                             ovf_reg;

    logic [dcrm_pkg::REM_W:0]         rem_shift;
    logic [dcrm_pkg::ALU_W-1:0]       alu_a;
    logic [dcrm_pkg::ALU_W-1:0]       alu_b;
    logic                             alu_sub;
    logic [dcrm_pkg::ALU_W:0]         alu_sum;
    logic                             alu_ge;
    logic                             last_step;

    // Pick the adder operands for the current operation
    always_comb
    begin
        rem_shift = {rem_reg, work_reg[dcrm_pkg::WORK_W-1]};
        if (op_reg == dcrm_pkg::IU_DIV)
        begin
            alu_a   = dcrm_pkg::ALU_W'(rem_shift);
            alu_b   = dcrm_pkg::ALU_W'(opb_reg[dcrm_pkg::REM_W-1:0]);
            alu_sub = 1'b1;
        end
        else
        begin
            alu_a   = dcrm_pkg::ALU_W'({acc_reg, 1'b0});
            alu_b   = work_reg[dcrm_pkg::WORK_W-1] ? dcrm_pkg::ALU_W'(opb_reg) : '0;
            alu_sub = 1'b0;
        end
    end

    // Shared adder; carry out on subtract means no borrow
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (dcrm_pkg::ALU_W + 1)'(alu_sub);
    assign alu_ge    = alu_sum[dcrm_pkg::ALU_W];
    assign last_step = busy_reg && (cnt_reg == dcrm_pkg::CNT_W'(1));

    // Control: step count, busy and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= dcrm_pkg::IU_DIV;
        end
        else
        begin
            done_reg <= last_step;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd.count;
                op_reg   <= cmd.op;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - dcrm_pkg::CNT_W'(1);
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: load operands, then shift one bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            work_reg <= opa;
            opb_reg  <= opb;
            rem_reg  <= '0;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (op_reg == dcrm_pkg::IU_DIV)
            begin
                work_reg <= {work_reg[dcrm_pkg::WORK_W-2:0], alu_ge};
                rem_reg  <= alu_ge ? alu_sum[dcrm_pkg::REM_W-1:0]
                                   : rem_shift[dcrm_pkg::REM_W-1:0];
            end
            else
            begin
                work_reg <= {work_reg[dcrm_pkg::WORK_W-2:0], 1'b0};
                acc_reg  <= alu_sum[dcrm_pkg::ACC_W-1:0];
                ovf_reg  <= ovf_reg | (|alu_sum[dcrm_pkg::ALU_W-1:dcrm_pkg::ACC_W]);
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quot      = work_reg;
    assign prod      = acc_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/depth_class_run_merger_unit.sv
// Top level: window classification, segment merging and segment emission.
// Sequencing: a word that does not close a segment is taken in the accept and evaluate states.
// A word that closes a segment runs the mean division, then, for the repeat class with a
// nonzero hap, the repeat ratio division, then the length multiply, all on one shared
// bit-serial unit, plus the sequencing states.
// Throughput: one word at a time; a finished segment waits in the output register.
// Reset: asynchronous, active low; no open segment, total cleared, both depths at 116.
`default_nettype none

module depth_class_run_merger_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dcrm_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [dcrm_pkg::PDATA_W-1:0]   pwdata,
    output logic [dcrm_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    dcrm_win_if.sink                            window,
    dcrm_seg_if.source                          segment
);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_EVAL       = 10'b00_0000_0010,
        S_MEAN_GO    = 10'b00_0000_0100,
        S_MEAN_WAIT  = 10'b00_0000_1000,
        S_RATIO_GO   = 10'b00_0001_0000,
        S_RATIO_WAIT = 10'b00_0010_0000,
        S_MUL_GO     = 10'b00_0100_0000,
        S_MUL_WAIT   = 10'b00_1000_0000,
        S_TOTAL      = 10'b01_0000_0000,
        S_OUT        = 10'b10_0000_0000
    } state_t;

    localparam logic [dcrm_pkg::HAP_W-1:0] HAP_RESET = dcrm_pkg::HAP_W'(116);

    // Classify a depth against thresholds k*hap + ceil(hap/2), k = 1..4
    function automatic dcrm_pkg::class_t classify(
        input logic [dcrm_pkg::DEPTH_BITS-1:0] depth,
        input logic [dcrm_pkg::HAP_W-1:0]      hap
    );
        logic [dcrm_pkg::HAP_W:0]   half_w;
        logic [dcrm_pkg::THR_W-1:0] thr;
        dcrm_pkg::class_t           cls;
        half_w = ({1'b0, hap} + (dcrm_pkg::HAP_W + 1)'(1)) >> 1;
        cls    = dcrm_pkg::CLS_REPEAT;
        for (int k = 4; k >= 1; k--)
        begin
            thr = dcrm_pkg::THR_W'(k) * dcrm_pkg::THR_W'(hap) + dcrm_pkg::THR_W'(half_w);
            if (dcrm_pkg::CMP_W'(depth) <= dcrm_pkg::CMP_W'(thr))
                cls = dcrm_pkg::class_t'(dcrm_pkg::CLASS_W'(k - 1));
        end
        return cls;
    endfunction

    state_t state_reg;
    state_t state_next;

    // Configuration
    logic [dcrm_pkg::HAP_W-1:0]          comb_hap_reg;
    logic [dcrm_pkg::HAP_W-1:0]          hifi_hap_reg;

    // Held input word
    logic                                in_kind_reg;
    logic [dcrm_pkg::CONTIG_ID_BITS-1:0] in_contig_reg;
    logic [dcrm_pkg::POS_W-1:0]          in_first_reg;
    logic [dcrm_pkg::POS_W-1:0]          in_last_reg;
    logic [dcrm_pkg::DEPTH_BITS-1:0]     in_cdep_reg;
    logic [dcrm_pkg::DEPTH_BITS-1:0]     in_hdep_reg;
    logic [dcrm_pkg::POS_W-1:0]          in_clen_reg;

    // Open segment
    logic                                seg_open_reg;
    logic [dcrm_pkg::CONTIG_ID_BITS-1:0] open_contig_reg;
    logic [dcrm_pkg::POS_W-1:0]          open_first_reg;
    logic [dcrm_pkg::POS_W-1:0]          open_last_reg;
    logic [dcrm_pkg::SUM_W-1:0]          depth_sum_reg;
    logic [dcrm_pkg::TALLY_W-1:0]        tally_reg;
    logic [dcrm_pkg::POS_W-1:0]          open_clen_reg;
    dcrm_pkg::class_t                    open_class_reg;
    logic [dcrm_pkg::TOTAL_W-1:0]        genome_total_reg;

    // Emission scratch
    logic [dcrm_pkg::MEAN_W-1:0]         mean_reg;
    logic [dcrm_pkg::QUOT_W-1:0]         q_reg;
    logic [dcrm_pkg::MULT_W-1:0]         mult_reg;
    logic [dcrm_pkg::ACC_W-1:0]          prod_reg;
    logic                                prod_ovf_reg;

    // Output register
    logic                                out_valid_reg;
    logic [dcrm_pkg::CONTIG_ID_BITS-1:0] out_contig_reg;
    logic [dcrm_pkg::POS_W-1:0]          out_first_reg;
    logic [dcrm_pkg::POS_W-1:0]          out_last_reg;
    logic [dcrm_pkg::MEAN_W-1:0]         out_mean_reg;
    logic [dcrm_pkg::TALLY_W-1:0]        out_tally_reg;
    logic [dcrm_pkg::POS_W-1:0]          out_clen_reg;
    logic [dcrm_pkg::CLASS_W-1:0]        out_class_reg;
    logic [dcrm_pkg::TOTAL_W-1:0]        out_total_reg;

    // Shared unit connection
    dcrm_pkg::iu_cmd_t                   iu_cmd;
    dcrm_pkg::iu_stat_t                  iu_stat;
    logic [dcrm_pkg::WORK_W-1:0]         iu_opa;
    logic [dcrm_pkg::MCAND_W-1:0]        iu_opb;
    logic [dcrm_pkg::WORK_W-1:0]         iu_quot;
    logic [dcrm_pkg::ACC_W-1:0]          iu_prod;

    // Combinational helpers
    logic                                in_accept;
    logic                                cfg_write;
    dcrm_pkg::class_t                    ccls;
    dcrm_pkg::class_t                    hcls;
    logic                                merge;
    logic                                is_repeat;
    logic                                out_load;
    logic [dcrm_pkg::SUM_W:0]            sum_ext;
    logic [dcrm_pkg::LEN_W-1:0]          seg_len;
    logic [dcrm_pkg::RATIO_DIVIDEND_W-1:0] ratio_dividend;
    logic [dcrm_pkg::TOTAL_W:0]          total_ext;

    // APB register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (dcrm_pkg::reg_idx_t'(paddr[2]))
            dcrm_pkg::REG_COMBINED_HAP: prdata = dcrm_pkg::PDATA_W'(comb_hap_reg);
            dcrm_pkg::REG_HIFI_HAP:     prdata = dcrm_pkg::PDATA_W'(hifi_hap_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_hap_reg <= HAP_RESET;
            hifi_hap_reg <= HAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (dcrm_pkg::reg_idx_t'(paddr[2]))
                dcrm_pkg::REG_COMBINED_HAP: comb_hap_reg <= pwdata[dcrm_pkg::HAP_W-1:0];
                dcrm_pkg::REG_HIFI_HAP:     hifi_hap_reg <= pwdata[dcrm_pkg::HAP_W-1:0];
                default:                    ;
            endcase
        end
    end

    // Classification and merge decision on the held word
    assign ccls      = classify(in_cdep_reg, comb_hap_reg);
    assign hcls      = classify(in_hdep_reg, hifi_hap_reg);
    assign merge     = (in_contig_reg == open_contig_reg)
                    && ((ccls == open_class_reg) || (hcls == open_class_reg));
    assign is_repeat = (open_class_reg == dcrm_pkg::CLS_REPEAT);
    assign sum_ext   = {1'b0, depth_sum_reg} + dcrm_pkg::SUM_W'(in_cdep_reg);

    // Segment length, zero when reversed
    assign seg_len = (open_last_reg >= open_first_reg)
                   ? ({1'b0, open_last_reg} - {1'b0, open_first_reg} + dcrm_pkg::LEN_W'(1))
                   : '0;

    assign ratio_dividend = dcrm_pkg::RATIO_DIVIDEND_W'({q_reg, 1'b0})
                          + dcrm_pkg::RATIO_DIVIDEND_W'(comb_hap_reg);
    assign total_ext      = {1'b0, genome_total_reg} + {1'b0, prod_reg};

    assign window.ready = (state_reg == S_IDLE);
    assign in_accept    = window.valid && window.ready;
    assign out_load     = (state_reg == S_OUT) && (!out_valid_reg || segment.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        iu_cmd     = '{start: 1'b0, op: dcrm_pkg::IU_DIV, count: '0};
        iu_opa     = '0;
        iu_opb     = '0;
        unique case (state_reg)
            S_IDLE:
                if (in_accept)
                    state_next = S_EVAL;
            S_EVAL:
                if (in_kind_reg)
                    state_next = seg_open_reg ? S_MEAN_GO : S_IDLE;
                else if (!seg_open_reg || merge)
                    state_next = S_IDLE;
                else
                    state_next = S_MEAN_GO;
            S_MEAN_GO:
            begin
                iu_cmd = '{start: 1'b1, op: dcrm_pkg::IU_DIV,
                           count: dcrm_pkg::CNT_W'(dcrm_pkg::DIV_MEAN_STEPS)};
                iu_opa = {depth_sum_reg, 8'h00};
                iu_opb = dcrm_pkg::MCAND_W'(tally_reg);
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
                if (iu_stat.done)
                    state_next = (is_repeat && (comb_hap_reg != '0)) ? S_RATIO_GO : S_MUL_GO;
            S_RATIO_GO:
            begin
                iu_cmd = '{start: 1'b1, op: dcrm_pkg::IU_DIV,
                           count: dcrm_pkg::CNT_W'(dcrm_pkg::DIV_RATIO_STEPS)};
                iu_opa = {ratio_dividend,
                          (dcrm_pkg::WORK_W - dcrm_pkg::RATIO_DIVIDEND_W)'(0)};
                iu_opb = dcrm_pkg::MCAND_W'({comb_hap_reg, 1'b0});
                state_next = S_RATIO_WAIT;
            end
            S_RATIO_WAIT:
                if (iu_stat.done)
                    state_next = S_MUL_GO;
            S_MUL_GO:
            begin
                if (is_repeat)
                begin
                    iu_cmd = '{start: 1'b1, op: dcrm_pkg::IU_MUL,
                               count: dcrm_pkg::CNT_W'(dcrm_pkg::MUL_REP_STEPS)};
                    iu_opa = {mult_reg, (dcrm_pkg::WORK_W - dcrm_pkg::MULT_W)'(0)};
                end
                else
                begin
                    iu_cmd = '{start: 1'b1, op: dcrm_pkg::IU_MUL,
                               count: dcrm_pkg::CNT_W'(dcrm_pkg::MUL_CLS_STEPS)};
                    iu_opa = {mult_reg[dcrm_pkg::CLASS_W-1:0],
                              (dcrm_pkg::WORK_W - dcrm_pkg::CLASS_W)'(0)};
                end
                iu_opb = seg_len;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
                if (iu_stat.done)
                    state_next = S_TOTAL;
            S_TOTAL:
                state_next = S_OUT;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    dcrm_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (iu_cmd),
        .opa   (iu_opa),
        .opb   (iu_opb),
        .stat  (iu_stat),
        .quot  (iu_quot),
        .prod  (iu_prod)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            seg_open_reg     <= 1'b0;
            genome_total_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Drop the result once taken, reload on emission
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (segment.ready)
                out_valid_reg <= 1'b0;

            // Open on the first window; flush without a segment clears the total
            if (state_reg == S_EVAL)
            begin
                if (in_kind_reg && !seg_open_reg)
                    genome_total_reg <= '0;
                else if (!in_kind_reg && !seg_open_reg)
                    seg_open_reg <= 1'b1;
            end

            // Saturating running total
            if (state_reg == S_TOTAL)
            begin
                if (prod_ovf_reg || total_ext[dcrm_pkg::TOTAL_W])
                    genome_total_reg <= '1;
                else
                    genome_total_reg <= total_ext[dcrm_pkg::TOTAL_W-1:0];
            end

            // After a flush emission close the segment and restart the stream
            if (out_load && in_kind_reg)
            begin
                seg_open_reg     <= 1'b0;
                genome_total_reg <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // Hold the accepted word
        if (in_accept)
        begin
            in_kind_reg   <= window.kind;
            in_contig_reg <= window.contig_id;
            in_first_reg  <= window.win_start;
            in_last_reg   <= window.win_end;
            in_cdep_reg   <= window.combined_depth;
            in_hdep_reg   <= window.hifi_depth;
            in_clen_reg   <= window.contig_length;
        end

        // Open a new segment or extend the open one
        if ((state_reg == S_EVAL && !in_kind_reg && !seg_open_reg)
            || (out_load && !in_kind_reg))
        begin
            open_contig_reg <= in_contig_reg;
            open_first_reg  <= in_first_reg;
            open_last_reg   <= in_last_reg;
            depth_sum_reg   <= dcrm_pkg::SUM_W'(in_cdep_reg);
            tally_reg       <= dcrm_pkg::TALLY_W'(1);
            open_clen_reg   <= in_clen_reg;
            open_class_reg  <= ccls;
        end
        else if (state_reg == S_EVAL && !in_kind_reg && seg_open_reg && merge)
        begin
            open_last_reg <= in_last_reg;
            depth_sum_reg <= sum_ext[dcrm_pkg::SUM_W] ? '1 : sum_ext[dcrm_pkg::SUM_W-1:0];
            if (tally_reg != '1)
                tally_reg <= tally_reg + dcrm_pkg::TALLY_W'(1);
        end

        // Capture the mean and the length multiplier
        if (state_reg == S_MEAN_WAIT && iu_stat.done)
        begin
            mean_reg <= (|iu_quot[dcrm_pkg::WORK_W-1:dcrm_pkg::MEAN_W])
                      ? '1 : iu_quot[dcrm_pkg::MEAN_W-1:0];
            q_reg    <= iu_quot[dcrm_pkg::WORK_W-1:8];
            if (is_repeat)
                mult_reg <= '0;
            else
                mult_reg <= dcrm_pkg::MULT_W'(dcrm_pkg::CLASS_W'(open_class_reg)
                                              + dcrm_pkg::CLASS_W'(1));
        end

        if (state_reg == S_RATIO_WAIT && iu_stat.done)
            mult_reg <= iu_quot[dcrm_pkg::MULT_W-1:0];

        if (state_reg == S_MUL_WAIT && iu_stat.done)
        begin
            prod_reg     <= iu_prod;
            prod_ovf_reg <= iu_stat.ovf;
        end

        // Load the output register
        if (out_load)
        begin
            out_contig_reg <= open_contig_reg;
            out_first_reg  <= open_first_reg;
            out_last_reg   <= open_last_reg;
            out_mean_reg   <= mean_reg;
            out_tally_reg  <= tally_reg;
            out_clen_reg   <= open_clen_reg;
            out_class_reg  <= open_class_reg;
            out_total_reg  <= genome_total_reg;
        end
    end

    assign segment.valid             = out_valid_reg;
    assign segment.seg_contig        = out_contig_reg;
    assign segment.seg_first         = out_first_reg;
    assign segment.seg_last          = out_last_reg;
    assign segment.mean_depth_x256   = out_mean_reg;
    assign segment.windows_merged    = out_tally_reg;
    assign segment.seg_contig_length = out_clen_reg;
    assign segment.seg_class         = out_class_reg;
    assign segment.represented_total = out_total_reg;

    // The shared unit is started only when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        iu_cmd.start |-> !iu_stat.busy)
        else $error("shared unit started while busy");

    // Unit completion is seen only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        iu_stat.done |-> (state_reg == S_MEAN_WAIT || state_reg == S_RATIO_WAIT
                          || state_reg == S_MUL_WAIT))
        else $error("shared unit finished outside a wait state");

    // An open segment always counts at least one window
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_open_reg |-> (tally_reg != '0))
        else $error("open segment with zero windows");

    // A window that closes a segment leaves a new one open
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !in_kind_reg) |=> seg_open_reg)
        else $error("segment not reopened after emission");

    // A flush emission clears the running total and closes the segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && in_kind_reg) |=> (genome_total_reg == '0) && !seg_open_reg)
        else $error("flush did not restart the stream");

endmodule

`default_nettype wire
